// ----- hw/rtl/sscr_pkg.sv -----
// Shared types, constants and helper functions for the strip chart renderer.
// Used by every module of the block; depends on nothing else.
package sscr_pkg;

    localparam int COLUMNS  = 64;
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int CNT_W    = $clog2(COLUMNS + 1);
    localparam int ROW_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = SAMPLE_W + ROW_W;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_BASE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RANGE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN  = 8'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value_max;
        logic [ROW_W-1:0]    y_base;
        logic [ROW_W-1:0]    y_range;
        logic [ROW_W-1:0]    x_origin;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rq_status_t;

    function automatic logic [COL_W-1:0] next_col(input logic [COL_W-1:0] p);
        logic [COL_W-1:0] r;
        if (p == COL_W'(COLUMNS - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/sscr_front.sv -----
// Front end: accepts samples, clamps and scales them to a screen row.
// Uses sscr_pkg; the scaling divide is a restoring divider, one bit a cycle.
module sscr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sscr_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sscr_pkg::SAMPLE_W-1:0] sample,
    input  sscr_pkg::rq_status_t          q_status,
    output logic                          push,
    output logic [sscr_pkg::ROW_W-1:0]    push_row
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [2:0]                        bit_reg, bit_next;
    logic [sscr_pkg::PROD_W-1:0]       rem_reg, rem_next;
    logic [sscr_pkg::ROW_W-1:0]        quo_reg, quo_next;
    logic [sscr_pkg::ROW_W-1:0]        span;
    logic [sscr_pkg::SAMPLE_W-1:0]     s_cl;
    logic [sscr_pkg::PROD_W-1:0]       prod;
    logic [sscr_pkg::PROD_W-1:0]       div_sh;
    logic [sscr_pkg::ROW_W-1:0]        quo_eff;

    assign span   = (cfg.y_range == '0) ? '0 : cfg.y_range - 1'b1;
    assign s_cl   = (sample > cfg.value_max) ? cfg.value_max : sample;
    assign prod   = sscr_pkg::PROD_W'(s_cl) * sscr_pkg::PROD_W'(span);
    assign div_sh = sscr_pkg::PROD_W'(cfg.value_max) << bit_reg;
    assign quo_eff  = (cfg.value_max == '0) ? '0 : quo_reg;
    assign push_row = cfg.y_base - 1'b1 - quo_eff;
    assign in_stall = (state_reg != F_IDLE);
    assign push     = (state_reg == F_PUSH) && !q_status.full;

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next   = prod;
                    quo_next   = '0;
                    bit_next   = 3'd7;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (rem_reg >= div_sh)
                begin
                    rem_next          = rem_reg - div_sh;
                    quo_next[bit_reg] = 1'b1;
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 3'd0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

// ----- hw/rtl/sscr_queue.sv -----
// Short row queue between the scaling front end and the drawing back end.
// Uses sscr_pkg for its depth and status type.
module sscr_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [sscr_pkg::ROW_W-1:0] push_row,
    input  logic                       pop,
    output logic [sscr_pkg::ROW_W-1:0] pop_row,
    output sscr_pkg::rq_status_t       status
);

    logic [sscr_pkg::ROW_W-1:0]  entry_reg [sscr_pkg::QDEPTH];
    logic [sscr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sscr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sscr_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == sscr_pkg::QCNT_W'(sscr_pkg::QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign pop_row      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sscr_pkg::QPTR_W'(sscr_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sscr_pkg::QPTR_W'(sscr_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_row;
        end
    end

endmodule

// ----- hw/rtl/sscr_back.sv -----
// Back end: keeps the row history in a ring memory and walks it, one draw
// command a cycle while out_stall is low, oldest column first. Uses sscr_pkg.
module sscr_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sscr_pkg::cfg_t             cfg,
    input  sscr_pkg::rq_status_t       q_status,
    input  logic [sscr_pkg::ROW_W-1:0] pop_row,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 x,
    output logic [sscr_pkg::ROW_W-1:0] y_start,
    output logic [sscr_pkg::ROW_W-1:0] y_end,
    output logic                       is_line,
    output logic                       last
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_LOAD0 = 2'd1;
    localparam logic [1:0] B_LOAD1 = 2'd2;
    localparam logic [1:0] B_EMIT  = 2'd3;

    logic [sscr_pkg::ROW_W-1:0] hist_mem [sscr_pkg::COLUMNS];

    logic [1:0]                  state_reg, state_next;
    logic [sscr_pkg::COL_W-1:0]  wp_reg, wp_next;
    logic [sscr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [sscr_pkg::COL_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [sscr_pkg::CNT_W-1:0]  fetch_reg, fetch_next;
    logic [sscr_pkg::COL_W-1:0]  emit_reg, emit_next;
    logic                        out_valid_reg, out_valid_next;
    logic [sscr_pkg::ROW_W-1:0]  first_row_reg;
    logic [sscr_pkg::ROW_W-1:0]  cur_reg, cur_next;
    logic [sscr_pkg::ROW_W-1:0]  rdata_reg;
    logic                        rd_first_reg;
    logic [7:0]                  x_reg;
    logic [sscr_pkg::ROW_W-1:0]  y_start_reg, y_end_reg;
    logic                        is_line_reg, last_reg;

    logic                        rd_en;
    logic [sscr_pkg::COL_W-1:0]  rd_addr;
    logic [sscr_pkg::CNT_W-1:0]  rd_logical;
    logic                        rd_first;
    logic                        load_out;
    logic [sscr_pkg::ROW_W-1:0]  rd_val;
    logic [sscr_pkg::ROW_W-1:0]  nxt;
    logic signed [sscr_pkg::ROW_W:0] diff;
    logic                        cmd_line;
    logic [sscr_pkg::ROW_W-1:0]  cmd_end;
    logic                        cmd_last;

    assign rd_val   = rd_first_reg ? first_row_reg : rdata_reg;
    assign cmd_last = (emit_reg == sscr_pkg::COL_W'(sscr_pkg::COLUMNS - 1));
    assign nxt      = cmd_last ? cur_reg : rd_val;
    assign diff     = $signed({1'b0, cur_reg}) - $signed({1'b0, nxt});
    assign cmd_line = (diff > 9'sd1) || (diff < -9'sd1);
    assign cmd_end  = !cmd_line ? cur_reg : ((diff > 9'sd0) ? nxt + 1'b1 : nxt - 1'b1);
    assign rd_first = (rd_logical < (sscr_pkg::CNT_W'(sscr_pkg::COLUMNS) - cnt_reg));
    assign pop      = (state_reg == B_IDLE) && !q_status.empty;
    assign load_out = (state_reg == B_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        fetch_next     = fetch_reg;
        emit_next      = emit_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        rd_en          = 1'b0;
        rd_addr        = rd_ptr_reg;
        rd_logical     = fetch_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    wp_next = sscr_pkg::next_col(wp_reg);
                    if (cnt_reg != sscr_pkg::CNT_W'(sscr_pkg::COLUMNS))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = B_LOAD0;
                end
            end
            B_LOAD0:
            begin
                rd_en       = 1'b1;
                rd_addr     = wp_reg;
                rd_logical  = '0;
                rd_ptr_next = sscr_pkg::next_col(wp_reg);
                fetch_next  = sscr_pkg::CNT_W'(1);
                state_next  = B_LOAD1;
            end
            B_LOAD1:
            begin
                cur_next    = rd_val;
                rd_en       = 1'b1;
                rd_ptr_next = sscr_pkg::next_col(rd_ptr_reg);
                fetch_next  = fetch_reg + 1'b1;
                emit_next   = '0;
                state_next  = B_EMIT;
            end
            B_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    cur_next       = rd_val;
                    if (fetch_reg < sscr_pkg::CNT_W'(sscr_pkg::COLUMNS))
                    begin
                        rd_en       = 1'b1;
                        rd_ptr_next = sscr_pkg::next_col(rd_ptr_reg);
                        fetch_next  = fetch_reg + 1'b1;
                    end
                    if (cmd_last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            rd_ptr_reg    <= '0;
            fetch_reg     <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            rd_ptr_reg    <= rd_ptr_next;
            fetch_reg     <= fetch_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hist_mem[wp_reg] <= pop_row;
        end
        if (rd_en)
        begin
            rdata_reg    <= hist_mem[rd_addr];
            rd_first_reg <= rd_first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (cnt_reg == '0))
        begin
            first_row_reg <= pop_row;
        end
        cur_reg <= cur_next;
        if (load_out)
        begin
            x_reg       <= cfg.x_origin + 8'(emit_reg);
            y_start_reg <= cur_reg;
            y_end_reg   <= cmd_end;
            is_line_reg <= cmd_line;
            last_reg    <= cmd_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign x         = x_reg;
    assign y_start   = y_start_reg;
    assign y_end     = y_end_reg;
    assign is_line   = is_line_reg;
    assign last      = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sscr_pkg::CNT_W'(sscr_pkg::COLUMNS))
        else $error("history fill count exceeds the column count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("row popped from an empty queue");

    a_walk_has_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> (cnt_reg != '0))
        else $error("history walked before the first row was stored");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && cmd_last) |=> (state_reg == B_IDLE) && out_valid_reg && last_reg)
        else $error("newest column command did not close the walk");

endmodule

// ----- hw/rtl/scrolling_strip_chart_renderer_top.sv -----
// Output: draw commands follow each sample transaction, one command a cycle while
// out_stall is low, COLUMNS commands in all, oldest column first.
// Sample rate: set by the history walk in the back end, while the scaling divide
// overlaps it through a two-entry queue.
// Reset: registers take their defaults and the history counts as empty; the first
// sample then stands for every column. No clearing pass is run.
module scrolling_strip_chart_renderer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sscr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sscr_pkg::SAMPLE_W-1:0]  sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     x,
    output logic [sscr_pkg::ROW_W-1:0]     y_start,
    output logic [sscr_pkg::ROW_W-1:0]     y_end,
    output logic                           is_line,
    output logic                           last
);

    sscr_pkg::cfg_t             cfg_reg;
    sscr_pkg::rq_status_t       q_status;
    logic                       push;
    logic [sscr_pkg::ROW_W-1:0] push_row;
    logic                       pop;
    logic [sscr_pkg::ROW_W-1:0] pop_row;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.value_max <= 16'd1023;
            cfg_reg.y_base    <= 8'd64;
            cfg_reg.y_range   <= 8'd64;
            cfg_reg.x_origin  <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sscr_pkg::CFG_VALUE_MAX: cfg_reg.value_max <= cfg_data;
                sscr_pkg::CFG_Y_BASE:    cfg_reg.y_base    <= cfg_data[7:0];
                sscr_pkg::CFG_Y_RANGE:   cfg_reg.y_range   <= cfg_data[7:0];
                sscr_pkg::CFG_X_ORIGIN:  cfg_reg.x_origin  <= cfg_data[7:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    sscr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .q_status (q_status),
        .push     (push),
        .push_row (push_row)
    );

    sscr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_row (push_row),
        .pop      (pop),
        .pop_row  (pop_row),
        .status   (q_status)
    );

    sscr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .pop_row   (pop_row),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x         (x),
        .y_start   (y_start),
        .y_end     (y_end),
        .is_line   (is_line),
        .last      (last)
    );

endmodule
